/* sv/gqce_pkg.sv */
// gqce_pkg: shared types, constants and register codes for glyph_quad_clip_emit
// used by every module of the block; depends on nothing
package gqce_pkg;

  localparam int DIV_BITS       = 16;
  localparam int QUEUE_DEPTH    = 16;
  localparam int VERTS_PER_QUAD = 6;
  localparam int ADDR_W         = 5;

  // corner selection per vertex: LT, RT, LB, RT, RB, LB (bit k is vertex k)
  localparam logic [VERTS_PER_QUAD-1:0] CORNER_RIGHT  = 6'b011010;
  localparam logic [VERTS_PER_QUAD-1:0] CORNER_BOTTOM = 6'b110100;

  localparam logic signed [20:0] OUT_MAX = 21'sd1048575;
  localparam logic signed [20:0] OUT_MIN = -21'sd1048576;

  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_SCALE_X     = 3'd4,
    REG_SCALE_Y     = 3'd5,
    REG_BIAS_X      = 3'd6,
    REG_BIAS_Y      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_RIGHT,
    SIDE_TOP,
    SIDE_BOTTOM
  } side_t;

  typedef struct packed {
    logic              keep;
    logic signed [23:0] rl;
    logic signed [23:0] rt;
    logic signed [23:0] rr;
    logic signed [23:0] rb;
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tr;
    logic [15:0]        tb;
    logic [31:0]        colour;
  } item_t;

  typedef struct packed {
    logic signed [20:0] x0;
    logic signed [20:0] x1;
    logic signed [20:0] y0;
    logic signed [20:0] y1;
    logic [15:0]        u0;
    logic [15:0]        u1;
    logic [15:0]        v0;
    logic [15:0]        v1;
    logic [31:0]        colour;
  } quad_t;

  typedef struct packed {
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic signed [31:0] bias_x;
    logic signed [31:0] bias_y;
  } map_cfg_t;

endpackage

/* sv/glyph_quad_clip_emit.sv */
// glyph_quad_clip_emit: top level, register file, four clip pipelines, mapping, emitter
// depends on gqce_pkg, gqce_clip, gqce_map, gqce_emit
//
//  channel   ports                             handshake
//  input     in_* fields                       start & !busy
//  result    out_* fields                      out_valid, one cycle, no stall
//  config    psel penable pwrite paddr pwdata  apb write, pready always high
//
// an accepted glyph passes four clip edges of 20 stages each, 16 of them one
// quotient bit of the texture shift, then 3 mapping stages, before the quad queue
// vertices leave one per cycle while the queue holds a quad, six per glyph
// busy rises when the queue plus items in flight reach QUEUE_DEPTH
// reset is synchronous and clears valid bits, counters and registers
module glyph_quad_clip_emit #(
  parameter int QUEUE_DEPTH = gqce_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [23:0]            in_rect_left,
  input  logic signed [23:0]            in_rect_top,
  input  logic signed [23:0]            in_rect_right,
  input  logic signed [23:0]            in_rect_bottom,
  input  logic [15:0]                   in_tex_left,
  input  logic [15:0]                   in_tex_top,
  input  logic [15:0]                   in_tex_right,
  input  logic [15:0]                   in_tex_bottom,
  input  logic [31:0]                   in_glyph_colour,
  output logic                          out_valid,
  output logic signed [20:0]            out_vertex_x,
  output logic signed [20:0]            out_vertex_y,
  output logic [15:0]                   out_tex_u,
  output logic [15:0]                   out_tex_v,
  output logic [31:0]                   out_vertex_colour,
  output logic                          out_last_vertex,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gqce_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [23:0]  cfg_clip_left_r, cfg_clip_top_r, cfg_clip_right_r, cfg_clip_bottom_r;
  gqce_pkg::map_cfg_t  cfg_map_r;
  gqce_pkg::reg_idx_t  cfg_idx;
  logic                cfg_wr;

  logic [CW-1:0]       inflight_r, inflight_nxt;
  logic                accept, reject, pop;

  gqce_pkg::item_t     in_item;
  gqce_pkg::item_t     it [0:4];
  logic                iv [0:4];
  logic                map_valid, map_keep;
  gqce_pkg::quad_t     map_quad;

  assign pready  = 1'b1;
  assign cfg_idx = gqce_pkg::reg_idx_t'(paddr[gqce_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_clip_left_r   <= '0;
      cfg_clip_top_r    <= '0;
      cfg_clip_right_r  <= '0;
      cfg_clip_bottom_r <= '0;
      cfg_map_r         <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gqce_pkg::REG_CLIP_LEFT:   cfg_clip_left_r   <= pwdata[23:0];
        gqce_pkg::REG_CLIP_TOP:    cfg_clip_top_r    <= pwdata[23:0];
        gqce_pkg::REG_CLIP_RIGHT:  cfg_clip_right_r  <= pwdata[23:0];
        gqce_pkg::REG_CLIP_BOTTOM: cfg_clip_bottom_r <= pwdata[23:0];
        gqce_pkg::REG_SCALE_X:     cfg_map_r.scale_x <= pwdata;
        gqce_pkg::REG_SCALE_Y:     cfg_map_r.scale_y <= pwdata;
        gqce_pkg::REG_BIAS_X:      cfg_map_r.bias_x  <= pwdata;
        gqce_pkg::REG_BIAS_Y:      cfg_map_r.bias_y  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gqce_pkg::REG_CLIP_LEFT:   prdata = {8'b0, cfg_clip_left_r};
      gqce_pkg::REG_CLIP_TOP:    prdata = {8'b0, cfg_clip_top_r};
      gqce_pkg::REG_CLIP_RIGHT:  prdata = {8'b0, cfg_clip_right_r};
      gqce_pkg::REG_CLIP_BOTTOM: prdata = {8'b0, cfg_clip_bottom_r};
      gqce_pkg::REG_SCALE_X:     prdata = cfg_map_r.scale_x;
      gqce_pkg::REG_SCALE_Y:     prdata = cfg_map_r.scale_y;
      gqce_pkg::REG_BIAS_X:      prdata = cfg_map_r.bias_x;
      gqce_pkg::REG_BIAS_Y:      prdata = cfg_map_r.bias_y;
      default:                   prdata = '0;
    endcase
  end

  // items in flight or waiting in the queue
  always_comb begin
    busy         = (inflight_r == CW'(QUEUE_DEPTH));
    accept       = start & ~busy;
    reject       = map_valid & ~map_keep;
    inflight_nxt = CW'(inflight_r + CW'(accept) - CW'(reject) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  always_comb begin
    in_item.keep   = 1'b1;
    in_item.rl     = in_rect_left;
    in_item.rt     = in_rect_top;
    in_item.rr     = in_rect_right;
    in_item.rb     = in_rect_bottom;
    in_item.tl     = in_tex_left;
    in_item.tt     = in_tex_top;
    in_item.tr     = in_tex_right;
    in_item.tb     = in_tex_bottom;
    in_item.colour = in_glyph_colour;
  end

  assign it[0] = in_item;
  assign iv[0] = accept;

  gqce_clip #(.SIDE(gqce_pkg::SIDE_LEFT)) u_clip_left (
    .clk(clk), .rst_n(rst_n), .clip_edge(cfg_clip_left_r),
    .in_valid(iv[0]), .in_item(it[0]), .out_valid(iv[1]), .out_item(it[1])
  );

  gqce_clip #(.SIDE(gqce_pkg::SIDE_RIGHT)) u_clip_right (
    .clk(clk), .rst_n(rst_n), .clip_edge(cfg_clip_right_r),
    .in_valid(iv[1]), .in_item(it[1]), .out_valid(iv[2]), .out_item(it[2])
  );

  gqce_clip #(.SIDE(gqce_pkg::SIDE_TOP)) u_clip_top (
    .clk(clk), .rst_n(rst_n), .clip_edge(cfg_clip_top_r),
    .in_valid(iv[2]), .in_item(it[2]), .out_valid(iv[3]), .out_item(it[3])
  );

  gqce_clip #(.SIDE(gqce_pkg::SIDE_BOTTOM)) u_clip_bottom (
    .clk(clk), .rst_n(rst_n), .clip_edge(cfg_clip_bottom_r),
    .in_valid(iv[3]), .in_item(it[3]), .out_valid(iv[4]), .out_item(it[4])
  );

  gqce_map u_map (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_map_r),
    .in_valid(iv[4]), .in_item(it[4]),
    .out_valid(map_valid), .out_keep(map_keep), .out_quad(map_quad)
  );

  gqce_emit #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_emit (
    .clk(clk), .rst_n(rst_n),
    .in_valid(map_valid & map_keep), .in_quad(map_quad), .pop(pop),
    .out_valid(out_valid), .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v), .out_vertex_colour(out_vertex_colour),
    .out_last_vertex(out_last_vertex)
  );

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CW'(QUEUE_DEPTH))
    else $error("in-flight count above queue depth");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_vertex |-> out_valid)
    else $error("last vertex without strobe");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (inflight_r != '0))
    else $error("quad finished with nothing in flight");

endmodule

/* sv/gqce_clip.sv */
// gqce_clip: one scissor edge, pipelined texture shift with one quotient bit per stage
// depends on gqce_pkg
module gqce_clip #(
  parameter gqce_pkg::side_t SIDE = gqce_pkg::SIDE_LEFT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [23:0]  clip_edge,
  input  logic                in_valid,
  input  gqce_pkg::item_t     in_item,
  output logic                out_valid,
  output gqce_pkg::item_t     out_item
);

  localparam int QB = gqce_pkg::DIV_BITS;
  localparam bit LOW_SIDE = (SIDE == gqce_pkg::SIDE_LEFT) || (SIDE == gqce_pkg::SIDE_TOP);
  localparam bit X_AXIS   = (SIDE == gqce_pkg::SIDE_LEFT) || (SIDE == gqce_pkg::SIDE_RIGHT);

  typedef struct packed {
    gqce_pkg::item_t item;
    logic            apply;
    logic            neg;
    logic [23:0]     d;
  } ctl_t;

  logic signed [23:0] lo, hi;
  logic [15:0]        tlo, thi;
  logic signed [24:0] over, span;
  logic               in_box, over_pos;
  logic [16:0]        tdiff;
  logic [15:0]        amag;
  ctl_t               c0_nxt;

  logic               v0_r, v1_r;
  ctl_t               c0_r, c1_r;
  logic [15:0]        amag0_r;
  logic [23:0]        over0_r;
  logic [39:0]        mag1_r, mag_nxt;
  logic [41:0]        num_nxt;

  logic               dv_r  [0:QB];
  ctl_t               dc_r  [0:QB];
  logic [25:0]        rem_r [0:QB];
  logic [QB-1:0]      nlo_r [0:QB];
  logic [QB-1:0]      q_r   [0:QB];

  logic               out_valid_r;
  gqce_pkg::item_t    out_item_r, out_item_nxt;
  logic [16:0]        sq;

  always_comb begin
    lo  = X_AXIS ? in_item.rl : in_item.rt;
    hi  = X_AXIS ? in_item.rr : in_item.rb;
    tlo = X_AXIS ? in_item.tl : in_item.tt;
    thi = X_AXIS ? in_item.tr : in_item.tb;
    over = LOW_SIDE ? ({clip_edge[23], clip_edge} - {lo[23], lo})
                    : ({hi[23], hi} - {clip_edge[23], clip_edge});
    in_box   = LOW_SIDE ? (clip_edge < hi) : (lo < clip_edge);
    over_pos = !over[24] && (over != 25'sd0);
    span  = {hi[23], hi} - {lo[23], lo};
    tdiff = {1'b0, thi} - {1'b0, tlo};
    amag  = tdiff[16] ? 16'(-tdiff) : tdiff[15:0];
    c0_nxt.item      = in_item;
    c0_nxt.item.keep = in_item.keep & ~(over_pos & ~in_box);
    c0_nxt.apply     = in_item.keep & over_pos & in_box;
    c0_nxt.neg       = tdiff[16];
    c0_nxt.d         = span[23:0];
  end

  assign mag_nxt = {24'b0, amag0_r} * {16'b0, over0_r};
  assign num_nxt = {1'b0, mag1_r, 1'b0} + {18'b0, c1_r.d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else begin
      v0_r     <= in_valid;
      v1_r     <= v0_r;
      dv_r[0]  <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    c0_r     <= c0_nxt;
    amag0_r  <= amag;
    over0_r  <= over[23:0];
    c1_r     <= c0_r;
    mag1_r   <= mag_nxt;
    dc_r[0]  <= c1_r;
    rem_r[0] <= num_nxt[41:16];
    nlo_r[0] <= num_nxt[15:0];
    q_r[0]   <= '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [26:0]   t, dd;
    logic          ge;
    logic [QB-1:0] q_nxt;

    always_comb begin
      t  = {rem_r[i], nlo_r[i][QB-1-i]};
      dd = {2'b0, dc_r[i].d, 1'b0};
      ge = (t >= dd);
      q_nxt = q_r[i];
      q_nxt[QB-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else begin
        dv_r[i+1] <= dv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      dc_r[i+1]  <= dc_r[i];
      rem_r[i+1] <= ge ? 26'(t - dd) : t[25:0];
      nlo_r[i+1] <= nlo_r[i];
      q_r[i+1]   <= q_nxt;
    end
  end

  always_comb begin
    sq = dc_r[QB].neg ? 17'(-{1'b0, q_r[QB]}) : {1'b0, q_r[QB]};
    out_item_nxt = dc_r[QB].item;
    if (dc_r[QB].apply) begin
      case (SIDE)
        gqce_pkg::SIDE_LEFT: begin
          out_item_nxt.rl = clip_edge;
          out_item_nxt.tl = dc_r[QB].item.tl + sq[15:0];
        end
        gqce_pkg::SIDE_RIGHT: begin
          out_item_nxt.rr = clip_edge;
          out_item_nxt.tr = dc_r[QB].item.tr - sq[15:0];
        end
        gqce_pkg::SIDE_TOP: begin
          out_item_nxt.rt = clip_edge;
          out_item_nxt.tt = dc_r[QB].item.tt + sq[15:0];
        end
        default: begin
          out_item_nxt.rb = clip_edge;
          out_item_nxt.tb = dc_r[QB].item.tb - sq[15:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/gqce_map.sv */
// gqce_map: three-stage mapping of clipped corners to device coordinates
// multiply, bias and round, then floor and saturate; depends on gqce_pkg
module gqce_map (
  input  logic               clk,
  input  logic               rst_n,
  input  gqce_pkg::map_cfg_t cfg,
  input  logic               in_valid,
  input  gqce_pkg::item_t    in_item,
  output logic               out_valid,
  output logic               out_keep,
  output gqce_pkg::quad_t    out_quad
);

  logic signed [56:0] p_nxt [4];
  logic signed [56:0] p_r   [4];
  logic signed [58:0] s_nxt [4];
  logic signed [58:0] s_r   [4];
  logic signed [58:0] bx, by;
  logic               va_r, vb_r, vc_r;
  logic               ka_r, kb_r, kc_r;
  logic [15:0]        ta_r [4];
  logic [15:0]        tb_r [4];
  logic [31:0]        cola_r, colb_r;
  gqce_pkg::quad_t    quad_r, quad_nxt;

  function automatic logic signed [20:0] round_sat(input logic signed [58:0] s);
    logic signed [38:0] sh;
    sh = 39'(s >>> 20);
    if (sh > 39'(gqce_pkg::OUT_MAX)) begin
      return gqce_pkg::OUT_MAX;
    end else if (sh < 39'(gqce_pkg::OUT_MIN)) begin
      return gqce_pkg::OUT_MIN;
    end
    return sh[20:0];
  endfunction

  always_comb begin
    p_nxt[0] = $signed({1'b0, cfg.scale_x}) * in_item.rl;
    p_nxt[1] = $signed({1'b0, cfg.scale_x}) * in_item.rr;
    p_nxt[2] = $signed({1'b0, cfg.scale_y}) * in_item.rt;
    p_nxt[3] = $signed({1'b0, cfg.scale_y}) * in_item.rb;
    bx = {{19{cfg.bias_x[31]}}, cfg.bias_x, 8'b0};
    by = {{19{cfg.bias_y[31]}}, cfg.bias_y, 8'b0};
    s_nxt[0] = {{2{p_r[0][56]}}, p_r[0]} + bx + 59'sd524288;
    s_nxt[1] = {{2{p_r[1][56]}}, p_r[1]} + bx + 59'sd524288;
    s_nxt[2] = 59'sd524288 - ({{2{p_r[2][56]}}, p_r[2]} + by);
    s_nxt[3] = 59'sd524288 - ({{2{p_r[3][56]}}, p_r[3]} + by);
    quad_nxt.x0 = round_sat(s_r[0]);
    quad_nxt.x1 = round_sat(s_r[1]);
    quad_nxt.y0 = round_sat(s_r[2]);
    quad_nxt.y1 = round_sat(s_r[3]);
    quad_nxt.u0 = tb_r[0];
    quad_nxt.u1 = tb_r[1];
    quad_nxt.v0 = tb_r[2];
    quad_nxt.v1 = tb_r[3];
    quad_nxt.colour = colb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      p_r[i]  <= p_nxt[i];
      s_r[i]  <= s_nxt[i];
      tb_r[i] <= ta_r[i];
    end
    ta_r[0] <= in_item.tl;
    ta_r[1] <= in_item.tr;
    ta_r[2] <= in_item.tt;
    ta_r[3] <= in_item.tb;
    cola_r  <= in_item.colour;
    colb_r  <= cola_r;
    ka_r    <= in_item.keep;
    kb_r    <= ka_r;
    kc_r    <= kb_r;
    quad_r  <= quad_nxt;
  end

  assign out_valid = vc_r;
  assign out_keep  = kc_r;
  assign out_quad  = quad_r;

endmodule

/* sv/gqce_emit.sv */
// gqce_emit: quad queue and six-vertex sequencer driving the result strobe
// depends on gqce_pkg
module gqce_emit #(
  parameter int QUEUE_DEPTH = gqce_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  gqce_pkg::quad_t    in_quad,
  output logic               pop,
  output logic               out_valid,
  output logic signed [20:0] out_vertex_x,
  output logic signed [20:0] out_vertex_y,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [31:0]        out_vertex_colour,
  output logic               out_last_vertex
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [2:0]    VTX_LAST = 3'(gqce_pkg::VERTS_PER_QUAD - 1);

  gqce_pkg::quad_t    mem [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [2:0]         vtx_r, vtx_nxt;
  logic               busy_q, valid_r;
  logic               right, bottom;
  logic signed [20:0] x_r, y_r;
  logic [15:0]        u_r, v_r;
  logic [31:0]        col_r;
  logic               last_r;

  always_comb begin
    busy_q     = (count_r != '0);
    pop        = busy_q && (vtx_r == VTX_LAST);
    vtx_nxt    = busy_q ? (pop ? 3'd0 : 3'(vtx_r + 3'd1)) : vtx_r;
    wr_ptr_nxt = in_valid ? ((wr_ptr_r == PTR_LAST) ? '0 : PW'(wr_ptr_r + 1'b1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? ((rd_ptr_r == PTR_LAST) ? '0 : PW'(rd_ptr_r + 1'b1)) : rd_ptr_r;
    count_nxt  = CW'(count_r + CW'(in_valid) - CW'(pop));
    right      = gqce_pkg::CORNER_RIGHT[vtx_r];
    bottom     = gqce_pkg::CORNER_BOTTOM[vtx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      vtx_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      vtx_r    <= vtx_nxt;
      valid_r  <= busy_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mem[wr_ptr_r] <= in_quad;
    end
    x_r    <= right  ? mem[rd_ptr_r].x1 : mem[rd_ptr_r].x0;
    y_r    <= bottom ? mem[rd_ptr_r].y1 : mem[rd_ptr_r].y0;
    u_r    <= right  ? mem[rd_ptr_r].u1 : mem[rd_ptr_r].u0;
    v_r    <= bottom ? mem[rd_ptr_r].v1 : mem[rd_ptr_r].v0;
    col_r  <= mem[rd_ptr_r].colour;
    last_r <= pop;
  end

  assign out_valid         = valid_r;
  assign out_vertex_x      = x_r;
  assign out_vertex_y      = y_r;
  assign out_tex_u         = u_r;
  assign out_tex_v         = v_r;
  assign out_vertex_colour = col_r;
  assign out_last_vertex   = last_r & valid_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("quad queue overflow");

  a_vtx_range: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_r <= VTX_LAST)
    else $error("vertex counter out of range");

  a_last_then_new: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (vtx_r == 3'd0))
    else $error("vertex counter not restarted after a quad");

endmodule
